// ===== sv/rgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgcd_pkg
// Shared types for the running GCD core: sequencer states, datapath
// operations and the control and status bundles between them.
// ----------------------------------------------------------------------------
`default_nettype none

package rgcd_pkg;

    localparam int unsigned FIELD_W = 31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_SCALE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_STEP,
        OP_SCALE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_unit_ctrl;

    typedef struct packed {
        logic done;
        logic k_zero;
    } t_unit_stat;

endpackage

`default_nettype wire

// ===== sv/rgcd_if.sv =====
// ----------------------------------------------------------------------------
// rgcd_in_if / rgcd_out_if
// Valid/ready channels for integer beats in and divisor beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgcd_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] value;
    logic        last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface rgcd_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);
endinterface

`default_nettype wire

// ===== sv/rgcd_unit.sv =====
// ----------------------------------------------------------------------------
// rgcd_unit
// Binary GCD datapath: one compare, one subtractor and one-bit shifts,
// stepped by the sequencer. Common factors of two are counted in k and
// restored by doubling at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcd_unit import rgcd_pkg::*; #(
    parameter int W = 31
) (
    input  wire logic         i_clk,
    input  wire t_unit_ctrl   i_ctrl,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output t_unit_stat        o_stat,
    output logic [W-1:0]      o_a
);

    localparam int KW = $clog2(W);

    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [KW-1:0] r_k;
    logic [W-1:0]  n_a;
    logic [W-1:0]  n_b;
    logic [KW-1:0] n_k;

    logic          a_gt;
    logic [W-1:0]  sub_x;
    logic [W-1:0]  sub_y;
    logic [W-1:0]  diff;
    logic [W-1:0]  half;

    always_comb begin
        a_gt  = r_a > r_b;
        sub_x = a_gt ? r_a : r_b;
        sub_y = a_gt ? r_b : r_a;
        diff  = sub_x - sub_y;
        half  = {1'b0, diff[W-1:1]};
    end

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        unique case (i_ctrl.op)
            OP_HOLD: begin
            end
            OP_LOAD: begin
                n_a = i_a;
                n_b = i_b;
                n_k = '0;
            end
            OP_STEP: begin
                priority if (r_a == '0) begin
                    n_a = r_b;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = {1'b0, r_a[W-1:1]};
                    n_b = {1'b0, r_b[W-1:1]};
                    n_k = r_k + 1'b1;
                end else if (!r_a[0]) begin
                    n_a = {1'b0, r_a[W-1:1]};
                end else if (!r_b[0]) begin
                    n_b = {1'b0, r_b[W-1:1]};
                end else if (a_gt) begin
                    n_a = half;
                end else begin
                    n_b = half;
                end
            end
            OP_SCALE: begin
                n_a = {r_a[W-2:0], 1'b0};
                n_k = r_k - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
    end

    assign o_stat.done   = (r_a == r_b);
    assign o_stat.k_zero = (r_k == '0);
    assign o_a           = r_a;

endmodule

`default_nettype wire

// ===== sv/running_gcd_of_sequence_core.sv =====
// ----------------------------------------------------------------------------
// running_gcd_of_sequence_core
// Running greatest common divisor over a run of integers.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one integer per beat; last marks the end of a run. The
//   first beat of a run sets the running divisor, later nonzero beats fold
//   in by binary GCD, zero beats are skipped. The beat with last set yields
//   one beat on o_out holding the divisor of the whole run.
//   Sequence: a first beat or a zero beat returns to idle, or goes to the
//   done state if last is set. A nonzero later beat runs the shared
//   subtract/shift unit: reduction steps, then one doubling per common
//   factor of two, with i_in.ready low until it is folded in. A last beat
//   then passes the done state, which loads the output register.
//   The output register holds a finished divisor while the receiver
//   stalls; non-last beats are still taken meanwhile, and a last beat
//   waits in the done state until the register is free.
//   Reset clears the output valid and returns to the idle state, ready for
//   the first beat of a new run.
// ----------------------------------------------------------------------------
`default_nettype none

module running_gcd_of_sequence_core import rgcd_pkg::*; #(
    parameter int VALUE_WIDTH = 31
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rgcd_in_if.sink     i_in,
    rgcd_out_if.source  o_out
);

    localparam int W = VALUE_WIDTH;

    t_state              r_state;
    t_state              n_state;
    logic [W-1:0]        r_divisor;
    logic                r_first;
    logic                r_last;
    logic                r_out_valid;
    logic [FIELD_W-1:0]  r_out_divisor;

    t_unit_ctrl          unit_ctrl;
    t_unit_stat          unit_stat;
    logic [W-1:0]        unit_a;

    logic [FIELD_W+W-1:0] in_ext;
    logic [W-1:0]         in_value;
    logic [W+FIELD_W-1:0] out_ext;
    logic                 in_fire;
    logic                 out_free;
    logic                 in_ready;

    assign in_ext   = {{W{1'b0}}, i_in.value};
    assign in_value = in_ext[W-1:0];
    assign out_ext  = {{FIELD_W{1'b0}}, r_divisor};
    assign in_fire  = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;

    rgcd_unit #(.W(W)) u_unit (
        .i_clk  (i_clk),
        .i_ctrl (unit_ctrl),
        .i_a    (r_divisor),
        .i_b    (in_value),
        .o_stat (unit_stat),
        .o_a    (unit_a)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!r_first && in_value != '0) begin
                        n_state = ST_GCD;
                    end else if (i_in.last) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_GCD: begin
                if (unit_stat.done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (unit_stat.k_zero) begin
                    n_state = r_last ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready     = 1'b0;
        unit_ctrl.op = OP_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                in_ready     = 1'b1;
                unit_ctrl.op = OP_LOAD;
            end
            ST_GCD: begin
                if (!unit_stat.done) begin
                    unit_ctrl.op = OP_STEP;
                end
            end
            ST_SCALE: begin
                if (!unit_stat.k_zero) begin
                    unit_ctrl.op = OP_SCALE;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && in_fire) begin
                r_first <= 1'b0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_first       <= 1'b1;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_fire) begin
            r_last <= i_in.last;
            if (r_first) begin
                r_divisor <= in_value;
            end
        end
        if (r_state == ST_SCALE && unit_stat.k_zero) begin
            r_divisor <= unit_a;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_divisor <= out_ext[FIELD_W-1:0];
        end
    end

    assign i_in.ready    = in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.divisor = r_out_divisor;

endmodule

`default_nettype wire

// ===== sv/rgcd_checker.sv =====
// ----------------------------------------------------------------------------
// rgcd_checker
// Port-level checks on the running GCD core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_last,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [30:0] i_out_divisor
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_divisor))
        else $error("stalled output beat dropped or changed");

    // drop output valid on reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // stall input right after a last beat is taken
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input taken right after last beat");

    // raise output valid only out of the done phase
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared while input was open");

endmodule

bind running_gcd_of_sequence_core rgcd_checker u_rgcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_last     (i_in.last),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_divisor (o_out.divisor)
);

`default_nettype wire
